// ===== hw/rtl/lppo_pkg.sv =====
// Shared types and constants for the long-press power-off detector.
// No dependencies; every other file imports this package.
`timescale 1ns / 1ps
`default_nettype none

package lppo_pkg;

  localparam int unsigned CfgIdxW = 2;

  localparam logic [CfgIdxW-1:0] CFG_DEBOUNCE_SAMPLES = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_HOLD_THRESHOLD   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RELEASE_SAMPLES  = 2'd2;

  localparam logic [7:0]  DEBOUNCE_SAMPLES_RST = 8'd10;
  localparam logic [15:0] HOLD_THRESHOLD_RST   = 16'd1500;
  localparam logic [7:0]  RELEASE_SAMPLES_RST  = 8'd3;

  typedef struct packed {
    logic pin_a_level;
    logic pin_b_level;
  } lppo_in_t;

  typedef struct packed {
    logic        key_pressed;
    logic        armed;
    logic        debounced_press;
    logic [15:0] hold_ticks;
    logic        power_off;
  } lppo_out_t;

  typedef struct packed {
    logic [7:0]  debounce_samples;
    logic [15:0] hold_threshold;
    logic [7:0]  release_samples;
  } lppo_cfg_t;

endpackage

`default_nettype wire

// ===== hw/rtl/lppo_cfg_regs.sv =====
// Configuration register file of the detector.
// Depends on lppo_pkg.
`timescale 1ns / 1ps
`default_nettype none

module lppo_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [lppo_pkg::CfgIdxW-1:0]   cfg_index,
  input  wire logic [15:0]                    cfg_data,
  output lppo_pkg::lppo_cfg_t                 cfg
);
  import lppo_pkg::*;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_samples <= DEBOUNCE_SAMPLES_RST;
      cfg.hold_threshold   <= HOLD_THRESHOLD_RST;
      cfg.release_samples  <= RELEASE_SAMPLES_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        CFG_DEBOUNCE_SAMPLES: cfg.debounce_samples <= cfg_data[7:0];
        CFG_HOLD_THRESHOLD:   cfg.hold_threshold   <= cfg_data;
        CFG_RELEASE_SAMPLES:  cfg.release_samples  <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/lppo_update.sv =====
// Detector state (boot latch, debounce, hold, sticky power-off) and next-state logic.
// Depends on lppo_pkg; result is combinational from the held sample and state.
`timescale 1ns / 1ps
`default_nettype none

module lppo_update (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 step,
  input  wire lppo_pkg::lppo_in_t   smp,
  input  wire lppo_pkg::lppo_cfg_t  cfg,
  output lppo_pkg::lppo_out_t       res_next
);
  import lppo_pkg::*;

  logic [7:0]  debounce_count, debounce_count_next;
  logic [15:0] hold_count, hold_count_next;
  logic [7:0]  release_count, release_count_next;
  logic        seen_released, seen_released_next;
  logic        off_latched, off_latched_next;
  logic        pressed;

  always_comb begin
    pressed             = ~(smp.pin_a_level & smp.pin_b_level);
    debounce_count_next = debounce_count;
    hold_count_next     = hold_count;
    release_count_next  = release_count;
    seen_released_next  = seen_released;
    off_latched_next    = off_latched;
    if (!off_latched) begin
      if (pressed) begin
        release_count_next = '0;
        if (seen_released) begin
          if (debounce_count < cfg.debounce_samples) begin
            debounce_count_next = debounce_count + 8'd1;
          end else begin
            if (hold_count < cfg.hold_threshold) begin
              hold_count_next = hold_count + 16'd1;
            end
            if (hold_count_next >= cfg.hold_threshold) begin
              off_latched_next = 1'b1;
            end
          end
        end
      end else begin
        debounce_count_next = '0;
        hold_count_next     = '0;
        if (!seen_released) begin
          if (release_count < cfg.release_samples) begin
            release_count_next = release_count + 8'd1;
          end
          if (release_count_next >= cfg.release_samples) begin
            seen_released_next = 1'b1;
          end
        end
      end
    end
    res_next.key_pressed     = pressed;
    res_next.armed           = seen_released_next;
    res_next.debounced_press = (debounce_count_next >= cfg.debounce_samples);
    res_next.hold_ticks      = hold_count_next;
    res_next.power_off       = off_latched_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_count <= '0;
      hold_count     <= '0;
      release_count  <= '0;
      seen_released  <= 1'b0;
      off_latched    <= 1'b0;
    end else if (step) begin
      debounce_count <= debounce_count_next;
      hold_count     <= hold_count_next;
      release_count  <= release_count_next;
      seen_released  <= seen_released_next;
      off_latched    <= off_latched_next;
    end
  end

  // power-off is sticky until reset
  a_off_sticky: assert property (@(posedge clk) disable iff (rst)
    off_latched |=> off_latched)
    else $error("power-off flag cleared without reset");

  a_off_needs_arm: assert property (@(posedge clk) disable iff (rst)
    off_latched |-> seen_released)
    else $error("power-off set while not armed");

  a_idle_when_unarmed: assert property (@(posedge clk) disable iff (rst)
    !seen_released |-> (debounce_count == 8'd0 && hold_count == 16'd0))
    else $error("counters moved before arming");

  a_release_clears: assert property (@(posedge clk) disable iff (rst)
    (step && !off_latched && smp.pin_a_level && smp.pin_b_level)
      |=> (hold_count == 16'd0 && debounce_count == 8'd0))
    else $error("release did not clear counters");

endmodule

`default_nettype wire

// ===== hw/rtl/long_press_power_off_detector_core.sv =====
// Top level of the long-press power-off detector: sample register, result register.
// Depends on lppo_pkg, lppo_cfg_regs and lppo_update.
//
//   channel   direction  handshake              payload
//   sample    in         sample_valid/stall     lppo_in_t   (two pin levels)
//   result    out        result_valid/stall     lppo_out_t  (one per sample)
//   cfg       in         cfg_valid/cfg_ready    cfg_index, cfg_data
//
// One sample per clock sustained while the result is not stalled; a result is presented once
// its sample has passed the sample register, then the result register, and is taken on an unstalled edge.
// Synchronous reset empties both registers, clears the state, restores defaults.
// A stalled result holds; a sample may still enter the sample register behind it.
// cfg_ready is always high.
`timescale 1ns / 1ps
`default_nettype none

module long_press_power_off_detector_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          sample_valid,
  output logic                               sample_stall,
  input  wire lppo_pkg::lppo_in_t            sample,
  output logic                               result_valid,
  input  wire logic                          result_stall,
  output lppo_pkg::lppo_out_t                result,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [lppo_pkg::CfgIdxW-1:0]  cfg_index,
  input  wire logic [15:0]                   cfg_data
);
  import lppo_pkg::*;

  lppo_cfg_t cfg;
  lppo_in_t  smp;
  lppo_out_t res_next;
  logic      smp_valid;
  logic      step;
  logic      res_free;

  lppo_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lppo_update u_update (
    .clk      (clk),
    .rst      (rst),
    .step     (step),
    .smp      (smp),
    .cfg      (cfg),
    .res_next (res_next)
  );

  assign res_free     = !result_valid || !result_stall;
  assign step         = smp_valid && res_free;
  assign sample_stall = smp_valid && !res_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      smp_valid <= 1'b0;
    end else if (!sample_stall) begin
      smp_valid <= sample_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!sample_stall && sample_valid) begin
      smp <= sample;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (res_free) begin
      result_valid <= smp_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      result <= res_next;
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking bench for long_press_power_off_detector_core: a scoreboard class predicts
// every status word from the pin samples and register writes, while tasks drive requests.
// Depends on lppo_pkg and the detector RTL only.
`timescale 1ns / 1ps

module testbench;
  import lppo_pkg::*;

  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;
  localparam int IDLE_LIMIT = 2000;
  localparam int HOLD_OFF_CYCLES = 250;
  localparam int RANDOM_PHASES = 10;
  localparam int PHASE_ITEMS = 100;
  localparam lppo_in_t PINS_RELEASED = '{pin_a_level: 1'b1, pin_b_level: 1'b1};

  class press_scoreboard;
    logic [7:0]  cfg_debounce;
    logic [15:0] cfg_hold;
    logic [7:0]  cfg_release;
    logic [7:0]  debounce_cnt;
    logic [15:0] hold_cnt;
    logic [7:0]  release_cnt;
    logic        armed_q;
    logic        off_q;
    lppo_out_t   due_status[$];
    int          errors;
    int          n_samples;
    int          n_pressed;
    int          n_checked;
    int          n_writes;
    int          deepest_hold;
    bit          off_seen;

    function new();
      cfg_debounce = DEBOUNCE_SAMPLES_RST;
      cfg_hold     = HOLD_THRESHOLD_RST;
      cfg_release  = RELEASE_SAMPLES_RST;
      debounce_cnt = '0;
      hold_cnt     = '0;
      release_cnt  = '0;
      armed_q      = 1'b0;
      off_q        = 1'b0;
      errors       = 0;
      n_samples    = 0;
      n_pressed    = 0;
      n_checked    = 0;
      n_writes     = 0;
      deepest_hold = 0;
      off_seen     = 1'b0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
      n_writes++;
      case (idx)
        CFG_DEBOUNCE_SAMPLES: cfg_debounce = data[7:0];
        CFG_HOLD_THRESHOLD:   cfg_hold = data;
        CFG_RELEASE_SAMPLES:  cfg_release = data[7:0];
        default: ;
      endcase
    endfunction

    // next pressed sample would latch power-off
    function bit press_would_trip();
      if (off_q || !armed_q || debounce_cnt < cfg_debounce) return 1'b0;
      if (hold_cnt < cfg_hold) return (17'(hold_cnt) + 17'd1) >= 17'(cfg_hold);
      return 1'b1;
    endfunction

    function lppo_out_t predict_status(lppo_in_t s);
      lppo_out_t o;
      logic pressed;
      pressed = !(s.pin_a_level & s.pin_b_level);
      if (!off_q) begin
        if (pressed) begin
          release_cnt = '0;
          if (armed_q) begin
            if (debounce_cnt < cfg_debounce) begin
              debounce_cnt = debounce_cnt + 8'd1;
            end else begin
              if (hold_cnt < cfg_hold) hold_cnt = hold_cnt + 16'd1;
              if (hold_cnt >= cfg_hold) off_q = 1'b1;
            end
          end
        end else begin
          debounce_cnt = '0;
          hold_cnt = '0;
          if (!armed_q) begin
            if (release_cnt < cfg_release) release_cnt = release_cnt + 8'd1;
            if (release_cnt >= cfg_release) armed_q = 1'b1;
          end
        end
      end
      o.key_pressed     = pressed;
      o.armed           = armed_q;
      o.debounced_press = debounce_cnt >= cfg_debounce;
      o.hold_ticks      = hold_cnt;
      o.power_off       = off_q;
      return o;
    endfunction

    function void note_sample(lppo_in_t s);
      lppo_out_t o;
      o = predict_status(s);
      due_status.push_back(o);
      n_samples++;
      if (o.key_pressed) n_pressed++;
    endfunction

    function int pending();
      return due_status.size();
    endfunction

    task report(string what, int unsigned exp_v, int unsigned got_v);
      if (errors < 50) begin
        $display("%0t: status mismatch on %s: expected %0d, got %0d", $realtime, what,
                 exp_v, got_v);
      end
      errors++;
    endtask

    task check_result(lppo_out_t got);
      lppo_out_t exp_s;
      if (due_status.size() == 0) begin
        report("unrequested result, hold_ticks", 0, got.hold_ticks);
        return;
      end
      exp_s = due_status.pop_front();
      n_checked++;
      if (got.hold_ticks > deepest_hold) deepest_hold = got.hold_ticks;
      if (got.power_off) off_seen = 1'b1;
      if (got.key_pressed !== exp_s.key_pressed)
        report("key_pressed", exp_s.key_pressed, got.key_pressed);
      if (got.armed !== exp_s.armed) report("armed", exp_s.armed, got.armed);
      if (got.debounced_press !== exp_s.debounced_press)
        report("debounced_press", exp_s.debounced_press, got.debounced_press);
      if (got.hold_ticks !== exp_s.hold_ticks)
        report("hold_ticks", exp_s.hold_ticks, got.hold_ticks);
      if (got.power_off !== exp_s.power_off)
        report("power_off", exp_s.power_off, got.power_off);
    endtask
  endclass

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                sample_valid = 1'b0;
  logic                sample_stall;
  lppo_in_t            sample = PINS_RELEASED;
  logic                result_valid;
  logic                result_stall = 1'b0;
  lppo_out_t           result;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [15:0]         cfg_data = '0;

  press_scoreboard sb = new();
  press_scoreboard plan = new();

  bit hold_off_req = 1'b0;
  bit steady = 1'b0;
  int burst_left = 0;
  int idle_cycles = 0;
  int stall_mode = 0;
  int mode_left = 0;
  int hold_left = 0;
  int cyc = 0;

  long_press_power_off_detector_core uut (
    .clk          (clk),
    .rst          (rst),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver: checks accepted results, stalls on its own pattern
  always @(posedge clk) begin
    cyc++;
    if (!rst && result_valid && !result_stall) sb.check_result(result);
    if (hold_left > 0) begin
      hold_left--;
      result_stall <= 1'b1;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_left = HOLD_OFF_CYCLES;
      result_stall <= 1'b1;
    end else begin
      if (mode_left <= 0) begin
        stall_mode = $urandom_range(0, 3);
        mode_left = $urandom_range(10, 80);
      end
      mode_left--;
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 3) == 0);
        2: result_stall <= ($urandom_range(0, 9) < 6);
        default: result_stall <= ((cyc % 5) < 2);
      endcase
    end
  end

  always @(posedge clk) begin
    if (!rst) begin
      if ((sample_valid && !sample_stall) || (result_valid && !result_stall) ||
          (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $realtime, IDLE_LIMIT);
        $display("long_press_power_off_detector_core regression: fail");
        $finish;
      end
    end
  end

  function automatic lppo_in_t pick_pins(bit pressed);
    if (!pressed) return PINS_RELEASED;
    return lppo_in_t'(2'($urandom_range(0, 2)));
  endfunction

  task automatic offer(input lppo_in_t s);
    int gap;
    if (!steady && burst_left <= 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        sample_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    void'(plan.predict_status(s));
    sample <= s;
    sample_valid <= 1'b1;
    do @(posedge clk); while (sample_stall);
    sb.note_sample(s);
  endtask

  task automatic offer_pressed(int n);
    repeat (n) offer(pick_pins(1'b1));
  endtask

  task automatic offer_noise(int n);
    repeat (n) offer(lppo_in_t'(2'($urandom_range(0, 3))));
  endtask

  task automatic wait_idle();
    sample_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [15:0] data);
    cfg_index <= idx;
    cfg_data <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    plan.write_reg(idx, data);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic pick_settings();
    int r;
    r = $urandom_range(0, 9);
    write_reg(CFG_DEBOUNCE_SAMPLES, (r == 0) ? 16'd0 : (r == 1) ? 16'd255 :
              16'($urandom_range(1, 12)));
    r = $urandom_range(0, 9);
    write_reg(CFG_HOLD_THRESHOLD, (r == 0) ? 16'hFFFF : (r == 1) ?
              16'($urandom_range(100, 300)) : 16'($urandom_range(1, 30)));
    write_reg(CFG_RELEASE_SAMPLES, 16'($urandom_range(0, 255)));
  endtask

  // press/release runs, press length aimed near the trip point; never latches power-off
  task automatic run_press_phase(int budget);
    int sent;
    int span;
    int run_len;
    lppo_in_t s;
    sent = 0;
    while (sent < budget) begin
      repeat ($urandom_range(1, 4)) begin
        if (sent < budget) begin
          offer(PINS_RELEASED);
          sent++;
        end
      end
      span = int'(plan.cfg_debounce) + int'(plan.cfg_hold);
      run_len = $urandom_range(0, 1) ? $urandom_range(0, span) : span - 2 + $urandom_range(0, 4);
      while (run_len > 0 && sent < budget) begin
        s = pick_pins(1'b1);
        if ($urandom_range(0, 9) == 0) s = lppo_in_t'(2'($urandom_range(0, 3)));
        if (s != PINS_RELEASED && plan.press_would_trip()) s = PINS_RELEASED;
        offer(s);
        sent++;
        run_len--;
      end
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // not yet armed at default settings: presses clear the release run
    offer('{1'b0, 1'b0});
    offer('{1'b0, 1'b1});
    offer('{1'b1, 1'b0});
    offer(PINS_RELEASED);
    offer(PINS_RELEASED);
    offer('{1'b0, 1'b1});
    offer(PINS_RELEASED);
    wait_idle();
    write_reg(CFG_UNUSED, 16'hFFFF);
    write_reg(CFG_RELEASE_SAMPLES, 16'd255);
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd255);
    repeat (3) offer(PINS_RELEASED);
    wait_idle();
    // zero release run arms on the first release
    write_reg(CFG_RELEASE_SAMPLES, 16'd0);
    offer('{1'b0, 1'b0});
    offer(PINS_RELEASED);
    offer(PINS_RELEASED);
    wait_idle();
    // zero debounce, widest hold threshold
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd0);
    write_reg(CFG_HOLD_THRESHOLD, 16'hFFFF);
    offer('{1'b0, 1'b0});
    offer('{1'b1, 1'b0});
    offer('{1'b0, 1'b1});
    offer(PINS_RELEASED);
    wait_idle();
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd5);
    write_reg(CFG_HOLD_THRESHOLD, 16'd100);
    offer_pressed(3);
    wait_idle();
    // debounce threshold dropped under the running count
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd2);
    offer_pressed(1);
    offer(PINS_RELEASED);

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      wait_idle();
      pick_settings();
      if (p == 4) begin
        steady = 1'b1;
        hold_off_req = 1'b1;
      end
      run_press_phase(PHASE_ITEMS);
      steady = 1'b0;
    end

    // hold threshold cut to zero mid-hold latches power-off, then everything freezes
    wait_idle();
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd2);
    write_reg(CFG_HOLD_THRESHOLD, 16'd1000);
    offer(PINS_RELEASED);
    offer_pressed(7);
    wait_idle();
    write_reg(CFG_HOLD_THRESHOLD, 16'd0);
    offer_pressed(1);
    offer_noise(15);
    wait_idle();
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd255);
    write_reg(CFG_UNUSED, 16'd0);
    offer_noise(5);
    wait_idle();
    write_reg(CFG_DEBOUNCE_SAMPLES, 16'd0);
    offer_noise(5);

    wait_idle();
    repeat (4) @(posedge clk);
    $display("Run covered %0d pin samples (%0d pressed), %0d status words, %0d reg writes.",
             sb.n_samples, sb.n_pressed, sb.n_checked, sb.n_writes);
    $display("Deepest hold count %0d, power-off latched %0d, %0d mismatches.",
             sb.deepest_hold, sb.off_seen, sb.errors);
    if (sb.errors == 0) begin
      $display("long_press_power_off_detector_core regression: pass");
    end else begin
      $display("long_press_power_off_detector_core regression: fail");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/lppo_pkg.sv
hw/rtl/lppo_cfg_regs.sv
hw/rtl/lppo_update.sv
hw/rtl/long_press_power_off_detector_core.sv
verif/testbench.sv
